>>> sv/cpu8_amr_pkg.sv
// Package for the 8-bit CPU operand-address resolver.
// Holds the addressing-mode codes, the opcode-to-mode table and the
// command and status types shared by the controller and the datapath.
package cpu8_amr_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 65536;

  typedef enum logic [3:0] {
    M_NOA = 4'd0,
    M_IMP = 4'd1,
    M_ACC = 4'd2,
    M_IMM = 4'd3,
    M_ZPG = 4'd4,
    M_ZPX = 4'd5,
    M_ZPY = 4'd6,
    M_ABS = 4'd7,
    M_ABX = 4'd8,
    M_ABY = 4'd9,
    M_IND = 4'd10,
    M_IDX = 4'd11,
    M_IDY = 4'd12,
    M_REL = 4'd13
  } mode_e;

  localparam mode_e MODE_TABLE [256] = '{
    M_IMP,M_IDX,M_NOA,M_NOA,M_NOA,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_ACC,M_NOA,M_NOA,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_NOA,M_ZPX,M_ZPX,M_NOA,M_IMP,M_ABY,M_ACC,M_NOA,M_NOA,M_ABX,M_ABX,M_NOA,
    M_ABS,M_IDX,M_NOA,M_NOA,M_ZPG,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_ACC,M_NOA,M_ABS,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_ZPX,M_ZPX,M_ZPX,M_NOA,M_IMP,M_ABY,M_ACC,M_NOA,M_ABX,M_ABX,M_ABX,M_NOA,
    M_IMP,M_IDX,M_NOA,M_NOA,M_NOA,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_ACC,M_NOA,M_ABS,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_NOA,M_ZPX,M_ZPX,M_NOA,M_IMP,M_ABY,M_NOA,M_NOA,M_NOA,M_ABX,M_ABX,M_NOA,
    M_IMP,M_IDX,M_NOA,M_NOA,M_NOA,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_ACC,M_NOA,M_IND,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_NOA,M_ZPX,M_ZPX,M_NOA,M_IMP,M_ABY,M_NOA,M_NOA,M_ABX,M_ABX,M_ABX,M_NOA,
    M_NOA,M_IDX,M_NOA,M_NOA,M_ZPG,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_IMP,M_NOA,M_ABS,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_ZPX,M_ZPX,M_ZPY,M_NOA,M_IMP,M_ABY,M_IMP,M_NOA,M_NOA,M_ABX,M_NOA,M_NOA,
    M_IMM,M_IDX,M_IMM,M_NOA,M_ZPG,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_IMP,M_NOA,M_ABS,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_ZPX,M_ZPX,M_ZPY,M_NOA,M_IMP,M_ABY,M_IMP,M_NOA,M_ABX,M_ABX,M_ABY,M_NOA,
    M_IMM,M_IDX,M_NOA,M_NOA,M_ZPG,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_IMP,M_NOA,M_ABS,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_NOA,M_ZPX,M_ZPX,M_NOA,M_IMP,M_ABY,M_NOA,M_NOA,M_NOA,M_ABX,M_ABX,M_NOA,
    M_IMM,M_IDX,M_NOA,M_NOA,M_ZPG,M_ZPG,M_ZPG,M_NOA,M_IMP,M_IMM,M_IMP,M_NOA,M_ABS,M_ABS,M_ABS,M_NOA,
    M_REL,M_IDY,M_ZPG,M_NOA,M_NOA,M_ZPX,M_ZPX,M_NOA,M_IMP,M_ABY,M_NOA,M_NOA,M_NOA,M_ABX,M_ABX,M_NOA
  };

  // Memory address source for the single RAM port.
  typedef enum logic [2:0] {
    ADDR_WR,
    ADDR_PC1,
    ADDR_PC2,
    ADDR_PTR,
    ADDR_PTR1,
    ADDR_EA
  } addr_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_B1,
    ST_RD_B2,
    ST_CALC,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_PTR_END,
    ST_OPR,
    ST_OPR_CAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic      load_item;
    logic      mem_we;
    addr_sel_e addr_sel;
    logic      cap_b1;
    logic      calc;
    logic      cap_lo;
    logic      ptr_end;
    logic      cap_val;
    logic      load_out;
  } amr_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic ptr_mode;
    logic fetch_mode;
    logic out_free;
  } amr_sts_t;

endpackage

>>> sv/cpu8_amr_in_if.sv
// Input channel of the operand-address resolver: valid, ready and the
// fields of one memory-write or resolve transaction. No dependencies.
interface cpu8_amr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;
  logic [7:0]  opcode;
  logic [15:0] prog_counter;
  logic [7:0]  acc_reg;
  logic [7:0]  index_x;
  logic [7:0]  index_y;

  modport source (
    output valid, kind, mem_addr, mem_data, opcode, prog_counter, acc_reg, index_x, index_y,
    input  ready
  );
  modport sink (
    input  valid, kind, mem_addr, mem_data, opcode, prog_counter, acc_reg, index_x, index_y,
    output ready
  );
endinterface

>>> sv/cpu8_amr_out_if.sv
// Output channel of the operand-address resolver: valid, ready and the
// mode, effective address and operand of one result. No dependencies.
interface cpu8_amr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [15:0] target_addr;
  logic [7:0]  operand_value;

  modport source (
    output valid, mode, target_addr, operand_value,
    input  ready
  );
  modport sink (
    input  valid, mode, target_addr, operand_value,
    output ready
  );
endinterface

>>> sv/cpu8_amr_ram.sv
// Generic single-port RAM with a registered read.
// Standalone; used for the resolver's byte memory.
module cpu8_amr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cpu8_amr_ctrl.sv
// Controller of the operand-address resolver: sequences the RAM reads of
// one transaction. Depends on cpu8_amr_pkg for the state and command types.
module cpu8_amr_ctrl
  import cpu8_amr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  amr_sts_t sts_i,
  output amr_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.in_kind) begin
          state_d = ST_RD_B1;
        end
      end
      ST_RD_B1:   state_d = ST_RD_B2;
      ST_RD_B2:   state_d = ST_CALC;
      ST_CALC: begin
        if (sts_i.ptr_mode) begin
          state_d = ST_PTR_LO;
        end else if (sts_i.fetch_mode) begin
          state_d = ST_OPR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PTR_LO:  state_d = ST_PTR_HI;
      ST_PTR_HI:  state_d = ST_PTR_END;
      ST_PTR_END: state_d = ST_OPR;
      ST_OPR:     state_d = ST_OPR_CAP;
      ST_OPR_CAP: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.addr_sel = ADDR_WR;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.mem_we    = in_valid_i && !sts_i.in_kind;
        cmd_o.load_item = in_valid_i && sts_i.in_kind;
      end
      ST_RD_B1:   cmd_o.addr_sel = ADDR_PC1;
      ST_RD_B2: begin
        cmd_o.addr_sel = ADDR_PC2;
        cmd_o.cap_b1   = 1'b1;
      end
      ST_CALC:    cmd_o.calc = 1'b1;
      ST_PTR_LO:  cmd_o.addr_sel = ADDR_PTR;
      ST_PTR_HI: begin
        cmd_o.addr_sel = ADDR_PTR1;
        cmd_o.cap_lo   = 1'b1;
      end
      ST_PTR_END: cmd_o.ptr_end = 1'b1;
      ST_OPR:     cmd_o.addr_sel = ADDR_EA;
      ST_OPR_CAP: cmd_o.cap_val = 1'b1;
      ST_DONE:    cmd_o.load_out = sts_i.out_free;
      default:    cmd_o.addr_sel = ADDR_WR;
    endcase
  end

  a_resolve_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.in_kind) |=> state_q == ST_RD_B1)
    else $error("resolve transaction did not start its operand reads");

  a_simple_mode_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && !sts_i.ptr_mode && !sts_i.fetch_mode) |=> state_q == ST_DONE)
    else $error("mode without memory operand went on reading");

endmodule

>>> sv/cpu8_amr_dp.sv
// Datapath of the operand-address resolver: item registers, address
// arithmetic, the byte memory and the output register.
// Depends on cpu8_amr_pkg and cpu8_amr_ram.
module cpu8_amr_dp
  import cpu8_amr_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  amr_cmd_t    cmd_i,
  output amr_sts_t    sts_o,
  input  logic        kind_i,
  input  logic [15:0] mem_addr_i,
  input  logic [7:0]  mem_data_i,
  input  logic [7:0]  opcode_i,
  input  logic [15:0] prog_counter_i,
  input  logic [7:0]  acc_reg_i,
  input  logic [7:0]  index_x_i,
  input  logic [7:0]  index_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  mode_o,
  output logic [15:0] target_addr_o,
  output logic [7:0]  operand_value_o
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  mode_e       mode_q;
  logic [15:0] pc_q;
  logic [7:0]  a_q, x_q, y_q;
  logic [7:0]  b1_q, lo_q;
  logic [15:0] ptr_q, ea_q;
  logic [7:0]  val_q;
  logic [15:0] ptr_d, ea_d;
  logic [7:0]  val_d;
  logic        out_valid_q;
  mode_e       out_mode_q;
  logic [15:0] out_ea_q;
  logic [7:0]  out_val_q;

  logic [15:0] addr;
  logic [7:0]  rdata;
  logic [15:0] word;
  logic [7:0]  zp_x, zp_y;

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_WR:   addr = mem_addr_i;
      ADDR_PC1:  addr = pc_q + 16'd1;
      ADDR_PC2:  addr = pc_q + 16'd2;
      ADDR_PTR:  addr = ptr_q;
      ADDR_PTR1: addr = ptr_q + 16'd1;
      ADDR_EA:   addr = ea_q;
      default:   addr = mem_addr_i;
    endcase
  end

  cpu8_amr_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .addr_i  (addr[AW-1:0]),
    .wdata_i (mem_data_i),
    .rdata_o (rdata)
  );

  // In the address-calculation step the RAM presents the byte at PC+2.
  assign word = {rdata, b1_q};
  assign zp_x = b1_q + x_q;
  assign zp_y = b1_q + y_q;

  always_comb begin
    ea_d  = ea_q;
    ptr_d = ptr_q;
    val_d = val_q;
    if (cmd_i.calc) begin
      ea_d  = '0;
      val_d = '0;
      case (mode_q)
        M_ACC:   val_d = a_q;
        M_IMM:   val_d = b1_q;
        M_ZPG:   ea_d = {8'd0, b1_q};
        M_ZPX:   ea_d = {8'd0, zp_x};
        M_ZPY:   ea_d = {8'd0, zp_y};
        M_ABS:   ea_d = word;
        M_ABX:   ea_d = word + {8'd0, x_q};
        M_ABY:   ea_d = word + {8'd0, y_q};
        M_IND:   ptr_d = word;
        M_IDX:   ptr_d = {8'd0, zp_x};
        M_IDY:   ptr_d = {8'd0, b1_q};
        M_REL:   ea_d = pc_q + 16'd2 + {{8{b1_q[7]}}, b1_q};
        default: ea_d = '0;
      endcase
    end else if (cmd_i.ptr_end) begin
      // Only the indirect-indexed mode adds Y to the fetched pointer.
      ea_d = {rdata, lo_q} + ((mode_q == M_IDY) ? {8'd0, y_q} : 16'd0);
    end else if (cmd_i.cap_val) begin
      val_d = rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= MODE_TABLE[opcode_i];
      pc_q   <= prog_counter_i;
      a_q    <= acc_reg_i;
      x_q    <= index_x_i;
      y_q    <= index_y_i;
    end
    if (cmd_i.cap_b1) begin
      b1_q <= rdata;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata;
    end
    ea_q  <= ea_d;
    ptr_q <= ptr_d;
    val_q <= val_d;
    if (cmd_i.load_out) begin
      out_mode_q <= mode_q;
      out_ea_q   <= ea_q;
      out_val_q  <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.in_kind    = kind_i;
  assign sts_o.ptr_mode   = mode_q inside {M_IND, M_IDX, M_IDY};
  assign sts_o.fetch_mode = mode_q inside {M_ZPG, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY};
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign mode_o          = out_mode_q;
  assign target_addr_o   = out_ea_q;
  assign operand_value_o = out_val_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before it was taken");

  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_we |-> (cmd_i.addr_sel == ADDR_WR))
    else $error("memory write on an operand read address");

  a_ptr_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ptr_end |-> $past(cmd_i.cap_lo, 1))
    else $error("pointer completed without its low byte");

endmodule

>>> sv/cpu8_address_mode_resolver.sv
// Operand-address resolver for an 8-bit CPU. A write transaction is stored while idle.
// Each read uses the single RAM port, one byte per read. A resolve reads the two bytes
// after the opcode and computes the address: implied, accumulator, immediate and relative
// modes finish there, zero-page and absolute forms read the operand, and indirect forms
// a pointer, then the operand. Input waits until the output register takes the result.
// The byte memory holds no reset; rst_ni (async, active low) clears control and out valid.
module cpu8_address_mode_resolver
  import cpu8_amr_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cpu8_amr_in_if.sink    in_i,
  cpu8_amr_out_if.source out_o
);

  // The controller steps through the reads of one transaction and issues a
  // command word each cycle; the datapath reports the class of the current
  // mode and whether the output register can take a new result.
  amr_cmd_t cmd;
  amr_sts_t sts;

  cpu8_amr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the byte memory, the address arithmetic and an output
  // register, so a finished result can wait while the next transaction starts.
  cpu8_amr_dp #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (in_i.kind),
    .mem_addr_i      (in_i.mem_addr),
    .mem_data_i      (in_i.mem_data),
    .opcode_i        (in_i.opcode),
    .prog_counter_i  (in_i.prog_counter),
    .acc_reg_i       (in_i.acc_reg),
    .index_x_i       (in_i.index_x),
    .index_y_i       (in_i.index_y),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .mode_o          (out_o.mode),
    .target_addr_o   (out_o.target_addr),
    .operand_value_o (out_o.operand_value)
  );

endmodule
